FILE: hw/rtl/ddc_pkg.sv
// Shared constants, register indexes and sine table helpers for the FM down-converter.
// No dependencies; every other file of the block but ddc_ram uses this package.
package ddc_pkg;

  // Default sizes of the block.
  localparam int TAPS_DEF       = 31;
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int COEF_W_DEF     = 18;

  // Fixed field and state widths.
  localparam int SAMPLE_W = 8;
  localparam int CIDX_W   = 5;
  localparam int LINE_W   = 24;
  localparam int AUDIO_W  = 16;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_PHASE_INC = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DECIM     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_THRESH    = 2'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN      = 2'd3;

  // Command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin(r/2^aw * pi/2) in Q30 by a nine-term Taylor series.
  function automatic logic [63:0] quarter_sine(input logic [63:0] r, input int aw);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (r * HALF_PI_Q30) >> aw;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // Q1.15 sine table entry k of a table with 2^aw entries.
  function automatic logic signed [15:0] sine_entry(input int k, input int aw);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] e;
    p = 64'(4 * k);
    q = p >> aw;
    r = p - (q << aw);
    if (q[0]) begin
      r = (64'd1 << aw) - r;
    end
    v = quarter_sine(r, aw);
    e = (v * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return (q >= 64'd2) ? -$signed(16'(e)) : $signed(16'(e));
  endfunction

endpackage

FILE: hw/rtl/ddc_in_if.sv
// Input channel of the FM down-converter: handshake plus sample and coefficient fields.
// Depends on ddc_pkg for the fixed field widths.
interface ddc_in_if #(parameter int COEF_W = ddc_pkg::COEF_W_DEF);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [ddc_pkg::SAMPLE_W-1:0]  sample_i;
  logic [ddc_pkg::SAMPLE_W-1:0]  sample_q;
  logic [ddc_pkg::CIDX_W-1:0]    coef_index;
  logic signed [COEF_W-1:0]      coef_value;

  modport source (output valid, command, sample_i, sample_q, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, command, sample_i, sample_q, coef_index, coef_value,
                  output ready);
endinterface

FILE: hw/rtl/ddc_out_if.sv
// Result channel of the FM down-converter: handshake plus the audio sample.
// Depends on ddc_pkg for the audio width.
interface ddc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddc_pkg::AUDIO_W-1:0]  audio_sample;

  modport source (output valid, audio_sample, input ready);
  modport sink   (input valid, audio_sample, output ready);
endinterface

FILE: hw/rtl/ddc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ddc_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ddc_fm_demodulator.sv
// FM down-converter top level: NCO mixer, decimating FIR over RAM delay lines, discriminator.
// Depends on ddc_pkg, ddc_in_if, ddc_out_if and ddc_ram.
// A load item leaves the block in IDLE. A sample item steps through SIN, COS, MUL and WR;
// a decimated one then runs the FIR pass, one tap per cycle from the line and tap RAMs, SCL,
// D1-D6, the 16-step divider (normalized path only) and OUT, held by any output stall.
// One item at a time; a finished result waits in the output register.
// Reset (synchronous, active low) restores register defaults and clears the phase, counters,
// previous sample and the valid bits of delay-line and tap entries, which then read as zero.
module ddc_fm_demodulator #(
  parameter int TAPS             = ddc_pkg::TAPS_DEF,
  parameter int SINE_TABLE_DEPTH = ddc_pkg::SINE_DEPTH_DEF,
  parameter int COEF_WIDTH       = ddc_pkg::COEF_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ddc_in_if.sink                      in_ch,
  ddc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [ddc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ddc_pkg::CFG_DW-1:0]  cfg_wdata
);
  import ddc_pkg::*;

  localparam int TAP_AW  = $clog2(TAPS);
  localparam int CNT_W   = $clog2(TAPS + 1);
  localparam int ROM_AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W  = COEF_WIDTH + LINE_W;
  localparam int ACC_W   = PROD_W + $clog2(TAPS);
  localparam int MIX_W   = SAMPLE_W + 1 + 16;
  localparam int DISC_W  = 2 * LINE_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SIN  = 4'd1;
  localparam logic [3:0] S_COS  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_WR   = 4'd4;
  localparam logic [3:0] S_FIR  = 4'd5;
  localparam logic [3:0] S_SCL  = 4'd6;
  localparam logic [3:0] S_D1   = 4'd7;
  localparam logic [3:0] S_D2   = 4'd8;
  localparam logic [3:0] S_D3   = 4'd9;
  localparam logic [3:0] S_D4   = 4'd10;
  localparam logic [3:0] S_D5   = 4'd11;
  localparam logic [3:0] S_D6   = 4'd12;
  localparam logic [3:0] S_DIV  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  // Configuration registers.
  logic [31:0] inc_r;
  logic [10:0] dec_r;
  logic [31:0] thr_r;
  logic [15:0] gain_r;

  // Control state.
  logic [3:0]        state_r, state_nxt;
  logic [31:0]       phase_r;
  logic [TAP_AW-1:0] wp_r;
  logic [10:0]       cnt_r;
  logic [TAPS-1:0]   line_vld_r;
  logic [TAPS-1:0]   tap_vld_r;
  logic [CNT_W-1:0]  j_r;
  logic [TAP_AW-1:0] k_r;
  logic              rdv_r, mulv_r, lv_r, tv_r;
  logic [3:0]        b_r;
  logic              out_valid_r;

  // Datapath registers.
  logic signed [SAMPLE_W:0]   ci_r, cq_r;
  logic [ROM_AW-1:0]          idx_r;
  logic signed [15:0]         sin_r, cos_r;
  logic signed [MIX_W-1:0]    p0_r, p1_r, p2_r, p3_r;
  logic signed [PROD_W-1:0]   prod_i_r, prod_q_r;
  logic signed [ACC_W-1:0]    acc_i_r, acc_q_r;
  logic signed [LINE_W-1:0]   fi_r, fq_r, pi_r, pq_r;
  logic signed [DISC_W-1:0]   pa_r, pb_r, pc_r, pd_r;
  logic signed [DISC_W:0]     d_r;
  logic [DISC_W:0]            mag_r;
  logic [DISC_W-1:0]          dmag_r;
  logic                       neg_r;
  logic [39:0]                hi_r, lo_r;
  logic [63:0]                rem_r;
  logic [15:0]                quo_r;
  logic signed [AUDIO_W-1:0]  out_data_r;

  // Sine table as constant logic.
  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, ROM_AW);
  end

  // Delay-line RAM holds I and Q of one entry side by side; tap RAM holds coefficients.
  logic                      line_we;
  logic [2*LINE_W-1:0]       line_wdata, line_rdata;
  logic                      tap_we;
  logic [TAP_AW-1:0]         tap_waddr;
  logic [COEF_WIDTH-1:0]     tap_rdata;
  logic                      in_acc;
  logic                      load_ok;
  logic signed [MIX_W:0]     mix_i_sum, mix_q_sum;
  logic [10:0]               cnt_inc, factor;
  logic                      fir_issue, fir_done;
  logic signed [LINE_W-1:0]  ld_i, ld_q;
  logic signed [COEF_WIDTH-1:0] tap_v;
  logic signed [ACC_W-1:0]   sh_i, sh_q;
  logic [63:0]               num, trial;
  logic                      out_free;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign load_ok   = int'(in_ch.coef_index) < TAPS;
  assign tap_we    = in_acc && (in_ch.command == CMD_LOAD) && load_ok;
  assign tap_waddr = TAP_AW'(in_ch.coef_index);
  assign line_we   = (state_r == S_WR);

  assign mix_i_sum  = (MIX_W + 1)'(p0_r) + (MIX_W + 1)'(p1_r);
  assign mix_q_sum  = (MIX_W + 1)'(p2_r) - (MIX_W + 1)'(p3_r);
  assign line_wdata = {LINE_W'($signed(mix_i_sum[MIX_W:7])),
                       LINE_W'($signed(mix_q_sum[MIX_W:7]))};

  ddc_ram #(.W(2 * LINE_W), .D(TAPS)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (wp_r),
    .wdata (line_wdata),
    .raddr (k_r),
    .rdata (line_rdata)
  );

  ddc_ram #(.W(COEF_WIDTH), .D(TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (in_ch.coef_value),
    .raddr (j_r[TAP_AW-1:0]),
    .rdata (tap_rdata)
  );

  // Decimation count and filter sequencing.
  assign cnt_inc   = cnt_r + 11'd1;
  assign factor    = (dec_r == 11'd0) ? 11'd1 : dec_r;
  assign fir_issue = (state_r == S_FIR) && (int'(j_r) < TAPS);
  assign fir_done  = (state_r == S_FIR) && !fir_issue && !rdv_r && !mulv_r;

  // Entries never written read as zero.
  assign ld_i  = lv_r ? $signed(line_rdata[2*LINE_W-1:LINE_W]) : '0;
  assign ld_q  = lv_r ? $signed(line_rdata[LINE_W-1:0]) : '0;
  assign tap_v = tv_r ? $signed(tap_rdata) : '0;

  // Floor shift of the accumulators back to 8 fractional bits.
  assign sh_i = acc_i_r >>> (COEF_WIDTH - 1);
  assign sh_q = acc_q_r >>> (COEF_WIDTH - 1);

  assign num   = {hi_r[39:0], 24'd0} + {24'd0, lo_r};
  assign trial = 64'(mag_r) << b_r;

  assign out_free = !out_valid_r || out_ch.ready;

  // Saturate a shifted accumulator to the signed 24-bit range.
  function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:LINE_W-1] == '0 || v[ACC_W-1:LINE_W-1] == '1) begin
      return v[LINE_W-1:0];
    end
    return {v[ACC_W-1], {(LINE_W - 1){~v[ACC_W-1]}}};
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.command == CMD_SAMPLE)) begin
          state_nxt = S_SIN;
        end
      end
      S_SIN: state_nxt = S_COS;
      S_COS: state_nxt = S_MUL;
      S_MUL: state_nxt = S_WR;
      S_WR:  state_nxt = (cnt_inc < factor) ? S_IDLE : S_FIR;
      S_FIR: begin
        if (fir_done) begin
          state_nxt = S_SCL;
        end
      end
      S_SCL: state_nxt = S_D1;
      S_D1:  state_nxt = S_D2;
      S_D2:  state_nxt = S_D3;
      S_D3:  state_nxt = S_D4;
      S_D4:  state_nxt = S_D5;
      S_D5:  state_nxt = S_D6;
      S_D6:  state_nxt = (mag_r > {17'd0, thr_r}) ? S_DIV : S_OUT;
      S_DIV: begin
        if (b_r == 4'd0) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inc_r       <= '0;
      dec_r       <= 11'd1;
      thr_r       <= 32'd66;
      gain_r      <= 16'd8000;
      phase_r     <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      line_vld_r  <= '0;
      tap_vld_r   <= '0;
      j_r         <= '0;
      k_r         <= '0;
      rdv_r       <= 1'b0;
      mulv_r      <= 1'b0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
      pi_r        <= '0;
      pq_r        <= '0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PHASE_INC: inc_r  <= cfg_wdata;
          REG_DECIM:     dec_r  <= cfg_wdata[10:0];
          REG_THRESH:    thr_r  <= cfg_wdata;
          REG_GAIN:      gain_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      if (tap_we) begin
        tap_vld_r[tap_waddr] <= 1'b1;
      end

      // Phase is used, then advanced.
      if (in_acc && (in_ch.command == CMD_SAMPLE)) begin
        phase_r <= phase_r + inc_r;
      end

      // Line write and decimation decision.
      if (state_r == S_WR) begin
        line_vld_r[wp_r] <= 1'b1;
        if (cnt_inc < factor) begin
          cnt_r <= cnt_inc;
          wp_r  <= (int'(wp_r) == TAPS - 1) ? '0 : wp_r + 1'b1;
        end else begin
          cnt_r <= '0;
          j_r   <= '0;
          k_r   <= wp_r;
        end
      end

      // Filter read pipeline: tap j pairs with line entry (wp - j) mod TAPS.
      rdv_r  <= fir_issue;
      mulv_r <= rdv_r;
      if (fir_issue) begin
        j_r <= j_r + 1'b1;
        k_r <= (k_r == '0) ? TAP_AW'(TAPS - 1) : k_r - 1'b1;
      end

      if (state_r == S_SCL) begin
        wp_r <= (int'(wp_r) == TAPS - 1) ? '0 : wp_r + 1'b1;
      end

      if (state_r == S_D2) begin
        pi_r <= fi_r;
        pq_r <= fq_r;
      end

      if (state_r == S_D6) begin
        b_r <= 4'd15;
      end else if (state_r == S_DIV) begin
        b_r <= b_r - 4'd1;
      end

      // Output register.
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.command == CMD_SAMPLE)) begin
      ci_r  <= $signed({1'b0, in_ch.sample_i}) - 9'sd128;
      cq_r  <= $signed({1'b0, in_ch.sample_q}) - 9'sd128;
      idx_r <= phase_r[31 -: ROM_AW];
    end
    if (state_r == S_SIN) begin
      sin_r <= sine_rom[idx_r];
    end
    if (state_r == S_COS) begin
      cos_r <= sine_rom[idx_r + ROM_AW'(SINE_TABLE_DEPTH / 4)];
    end
    if (state_r == S_MUL) begin
      p0_r <= ci_r * cos_r;
      p1_r <= cq_r * sin_r;
      p2_r <= cq_r * cos_r;
      p3_r <= ci_r * sin_r;
    end

    // Filter multiply and accumulate.
    if (state_r == S_WR) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (mulv_r) begin
      acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
      acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
    end
    lv_r     <= line_vld_r[k_r];
    tv_r     <= tap_vld_r[j_r[TAP_AW-1:0]];
    prod_i_r <= tap_v * ld_i;
    prod_q_r <= tap_v * ld_q;

    // Discriminator.
    if (state_r == S_SCL) begin
      fi_r <= sat_line(sh_i);
      fq_r <= sat_line(sh_q);
    end
    if (state_r == S_D1) begin
      pa_r <= fi_r * pq_r;
      pb_r <= fq_r * pi_r;
    end
    if (state_r == S_D2) begin
      pc_r <= fi_r * fi_r;
      pd_r <= fq_r * fq_r;
      d_r  <= (DISC_W + 1)'(pa_r) - (DISC_W + 1)'(pb_r);
    end
    if (state_r == S_D3) begin
      mag_r  <= {1'b0, pc_r} + {1'b0, pd_r};
      neg_r  <= d_r[DISC_W];
      dmag_r <= d_r[DISC_W] ? DISC_W'(-d_r) : DISC_W'(d_r);
    end
    if (state_r == S_D4) begin
      hi_r <= dmag_r[DISC_W-1:24] * gain_r;
      lo_r <= dmag_r[23:0] * gain_r;
    end
    if (state_r == S_D5) begin
      rem_r <= num;
    end

    // Weak signal: scale by 2^-16; otherwise restoring division, one bit a cycle.
    if (state_r == S_D6) begin
      if (mag_r > {17'd0, thr_r}) begin
        quo_r <= '0;
      end else if (|rem_r[63:31]) begin
        quo_r <= 16'h7FFF;
      end else begin
        quo_r <= {1'b0, rem_r[30:16]};
      end
    end else if (state_r == S_DIV) begin
      if (rem_r >= trial) begin
        rem_r       <= rem_r - trial;
        quo_r[b_r]  <= 1'b1;
      end
    end

    if (state_r == S_OUT && out_free) begin
      if (quo_r[15]) begin
        out_data_r <= neg_r ? -16'sd32767 : 16'sd32767;
      end else begin
        out_data_r <= neg_r ? -$signed({1'b0, quo_r[14:0]}) : $signed({1'b0, quo_r[14:0]});
      end
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.audio_sample = out_data_r;

endmodule

FILE: hw/rtl/ddc_chk.sv
// Port-level checks for the FM down-converter, attached to the top level by bind.
// Depends on ddc_pkg for field widths and command codes.
module ddc_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_command,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ddc_pkg::AUDIO_W-1:0] out_audio
);
  import ddc_pkg::*;

  // A pending result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Saturation never yields the most negative code.
  a_out_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_audio != 16'sh8000)
    else $error("audio sample outside saturation range");

  // A sample item keeps the block busy for the next cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_SAMPLE |=> !in_ready)
    else $error("ready after a sample item");

  // A load item leaves the block ready in the next cycle.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_LOAD |=> in_ready)
    else $error("busy after a load item");

endmodule

bind ddc_fm_demodulator ddc_chk u_ddc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_audio  (out_ch.audio_sample)
);
